// ===== hw/rtl/bmhpq_pkg.sv =====
// Shared constants and controller/datapath interface types for the heap queue.
package bmhpq_pkg;

    localparam int DEPTH  = 31;
    localparam int KEY_W  = 32;
    localparam int CNT_W  = 5;
    localparam int ADDR_W = 5;

    localparam logic [CNT_W-1:0]  CAPACITY_RESET = CNT_W'(31);
    localparam logic [ADDR_W-1:0] ROOT_ADDR      = ADDR_W'(1);

    localparam logic ACTION_INSERT = 1'b0;
    localparam logic ACTION_REMOVE = 1'b1;

    // Commands from the controller, one or none active per cycle.
    typedef struct packed {
        logic ins_start;   // start the key at the next free slot, bump count
        logic refuse;      // mark request as refused
        logic rm_start;    // read root and last entry
        logic rm_load;     // take root, move last entry up, drop count
        logic rd_parent;   // read the parent of the current slot
        logic up_shift;    // move parent down into the current slot
        logic rd_children; // read both children of the current slot
        logic dn_shift;    // move larger child up into the current slot
        logic write_final; // store the moving key at the current slot
        logic load_out;    // load the result register
    } cmd_t;

    // Status from the datapath.
    typedef struct packed {
        logic full;        // no room for an insert
        logic empty;       // nothing to remove
        logic pos_root;    // current slot is the root
        logic up_move;     // moving key beats its parent
        logic has_child;   // current slot has at least one child
        logic dn_move;     // larger child beats the moving key
    } status_t;

endpackage

// ===== hw/rtl/bmhpq_ctrl.sv =====
// Controller state machine for the heap queue: sequences insert and remove.
module bmhpq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              action,
    input  logic              out_stall,
    input  bmhpq_pkg::status_t status,
    output bmhpq_pkg::cmd_t   cmd,
    output logic              in_stall,
    output logic              out_valid
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RM_LOAD,
        ST_UP_CHECK,
        ST_UP_CMP,
        ST_DN_CHECK,
        ST_DN_CMP,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == bmhpq_pkg::ACTION_INSERT)
                    begin
                        if (status.full)
                        begin
                            cmd.refuse = 1'b1;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cmd.ins_start = 1'b1;
                            state_next    = ST_UP_CHECK;
                        end
                    end
                    else
                    begin
                        if (status.empty)
                        begin
                            cmd.refuse = 1'b1;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cmd.rm_start = 1'b1;
                            state_next   = ST_RM_LOAD;
                        end
                    end
                end
            end
            ST_RM_LOAD:
            begin
                cmd.rm_load = 1'b1;
                state_next  = ST_DN_CHECK;
            end
            ST_UP_CHECK:
            begin
                if (status.pos_root)
                begin
                    cmd.write_final = 1'b1;
                    state_next      = ST_FINISH;
                end
                else
                begin
                    cmd.rd_parent = 1'b1;
                    state_next    = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                if (status.up_move)
                begin
                    cmd.up_shift = 1'b1;
                    state_next   = ST_UP_CHECK;
                end
                else
                begin
                    cmd.write_final = 1'b1;
                    state_next      = ST_FINISH;
                end
            end
            ST_DN_CHECK:
            begin
                if (status.has_child)
                begin
                    cmd.rd_children = 1'b1;
                    state_next      = ST_DN_CMP;
                end
                else
                begin
                    cmd.write_final = 1'b1;
                    state_next      = ST_FINISH;
                end
            end
            ST_DN_CMP:
            begin
                if (status.dn_move)
                begin
                    cmd.dn_shift = 1'b1;
                    state_next   = ST_DN_CHECK;
                end
                else
                begin
                    cmd.write_final = 1'b1;
                    state_next      = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/bmhpq_datapath.sv =====
// Datapath for the heap queue: heap memory, sift registers and result register.
module bmhpq_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic        [bmhpq_pkg::CNT_W-1:0]  cfg_write_data,
    input  logic signed [bmhpq_pkg::KEY_W-1:0]  key,
    input  bmhpq_pkg::cmd_t                     cmd,
    output bmhpq_pkg::status_t                  status,
    output logic                                accepted,
    output logic signed [bmhpq_pkg::KEY_W-1:0]  removed_key,
    output logic        [bmhpq_pkg::CNT_W-1:0]  count_after
);

    localparam int KW = bmhpq_pkg::KEY_W;
    localparam int CW = bmhpq_pkg::CNT_W;
    localparam int AW = bmhpq_pkg::ADDR_W;

    logic signed [KW-1:0] heap_mem [0:bmhpq_pkg::DEPTH];

    logic        [CW-1:0] capacity_reg;
    logic        [CW-1:0] count_reg;
    logic        [AW-1:0] pos_reg;
    logic signed [KW-1:0] moving_reg;
    logic signed [KW-1:0] taken_reg;
    logic                 acc_reg;
    logic signed [KW-1:0] rdata_a_reg;
    logic signed [KW-1:0] rdata_b_reg;

    logic                 out_acc_reg;
    logic signed [KW-1:0] out_key_reg;
    logic        [CW-1:0] out_count_reg;

    logic        [AW-1:0] child_addr;
    logic                 take_right;
    logic        [AW-1:0] sel_addr;
    logic signed [KW-1:0] sel_val;
    logic        [AW-1:0] rd_a_addr;
    logic        [AW-1:0] rd_b_addr;
    logic                 mem_we;
    logic signed [KW-1:0] mem_wdata;

    // Left child of the current slot; slot stays within the first half here.
    assign child_addr = {pos_reg[AW-2:0], 1'b0};
    assign take_right = (child_addr < count_reg) && (rdata_a_reg < rdata_b_reg);
    assign sel_addr   = take_right ? (child_addr + AW'(1)) : child_addr;
    assign sel_val    = take_right ? rdata_b_reg : rdata_a_reg;

    always_comb
    begin
        priority if (cmd.rm_start)
        begin
            rd_a_addr = bmhpq_pkg::ROOT_ADDR;
            rd_b_addr = count_reg;
        end
        else if (cmd.rd_parent)
        begin
            rd_a_addr = pos_reg >> 1;
            rd_b_addr = pos_reg >> 1;
        end
        else
        begin
            rd_a_addr = child_addr;
            rd_b_addr = child_addr + AW'(1);
        end
    end

    assign mem_we    = cmd.up_shift || cmd.dn_shift || cmd.write_final;
    assign mem_wdata = cmd.up_shift ? rdata_a_reg : (cmd.dn_shift ? sel_val : moving_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[pos_reg] <= mem_wdata;
        end
        rdata_a_reg <= heap_mem[rd_a_addr];
        rdata_b_reg <= heap_mem[rd_b_addr];
    end

    assign status.full      = (count_reg >= capacity_reg) ||
                              (count_reg >= CW'(bmhpq_pkg::DEPTH));
    assign status.empty     = (count_reg == '0);
    assign status.pos_root  = (pos_reg == bmhpq_pkg::ROOT_ADDR);
    assign status.up_move   = (moving_reg > rdata_a_reg);
    assign status.has_child = (pos_reg <= (count_reg >> 1));
    assign status.dn_move   = (moving_reg < sel_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= bmhpq_pkg::CAPACITY_RESET;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                capacity_reg <= cfg_write_data;
            end
            if (cmd.ins_start)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.rm_load)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_start)
        begin
            pos_reg    <= count_reg + AW'(1);
            moving_reg <= key;
            taken_reg  <= '0;
            acc_reg    <= 1'b1;
        end
        if (cmd.refuse)
        begin
            taken_reg <= '0;
            acc_reg   <= 1'b0;
        end
        if (cmd.rm_start)
        begin
            acc_reg <= 1'b1;
        end
        if (cmd.rm_load)
        begin
            taken_reg  <= rdata_a_reg;
            moving_reg <= rdata_b_reg;
            pos_reg    <= bmhpq_pkg::ROOT_ADDR;
        end
        if (cmd.up_shift)
        begin
            pos_reg <= pos_reg >> 1;
        end
        if (cmd.dn_shift)
        begin
            pos_reg <= sel_addr;
        end
        if (cmd.load_out)
        begin
            out_acc_reg   <= acc_reg;
            out_key_reg   <= taken_reg;
            out_count_reg <= count_reg;
        end
    end

    assign accepted    = out_acc_reg;
    assign removed_key = out_key_reg;
    assign count_after = out_count_reg;

endmodule

// ===== hw/rtl/binary_max_heap_priority_queue_unit.sv =====
// Top level of the binary max-heap priority queue.
//
// Request channel: in_valid/in_stall with action (0 insert, 1 remove) and key.
// Result channel: out_valid/out_stall with accepted, removed_key, count_after;
// every request yields exactly one result, in request order.
// Configuration: cfg_write_en/cfg_write_data write capacity (reset 31); write
// it only while no request is in flight.
//
// Steps: a refused request goes straight to its result; an insert climbs one
// level per parent read and shift, then writes the key; a remove reads the
// root and last entry, moves the last entry up, then sinks it one level per
// children read and shift and writes it. A sift covers at most 4 levels with
// 31 slots; each level needs one registered read and one write.
// One request is in work at a time; in_stall is high while it runs.
// The result sits in an output register, so a new request is taken while an
// earlier result still waits; if the receiver stalls, the finished request
// holds in the controller until the output register frees.
// Reset clears the count (queue empty), restores capacity to 31 and drops
// any pending result; heap contents are not cleared, as the value of an
// unwritten slot is never used.
module binary_max_heap_priority_queue_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic        [bmhpq_pkg::CNT_W-1:0]  cfg_write_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                action,
    input  logic signed [bmhpq_pkg::KEY_W-1:0]  key,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                accepted,
    output logic signed [bmhpq_pkg::KEY_W-1:0]  removed_key,
    output logic        [bmhpq_pkg::CNT_W-1:0]  count_after
);

    bmhpq_pkg::cmd_t    cmd;
    bmhpq_pkg::status_t status;

    // Sequence each request: start, climb or sink one level per read and shift,
    // then hand the result to the output register.
    bmhpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    // Hold the heap, the count, capacity and the result payload.
    bmhpq_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .key            (key),
        .cmd            (cmd),
        .status         (status),
        .accepted       (accepted),
        .removed_key    (removed_key),
        .count_after    (count_after)
    );

endmodule
